[hdl/sm3_pkg.sv]
// ----------------------------------------------------------------------------
// SM3 hash engine package
// Shared types, constants and round functions of the SM3 hash engine.
// ----------------------------------------------------------------------------
package sm3_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NbW     = 3;
  localparam int unsigned CntW    = 61;
  localparam int unsigned BlkWords = 16;
  localparam int unsigned Rounds  = 64;

  localparam logic [WordW-1:0] TConstLow  = 32'h79cc4519;
  localparam logic [WordW-1:0] TConstHigh = 32'h9d8a7a87;
  localparam logic [WordW-1:0] PadWord    = 32'h80000000;

  localparam logic [WordW-1:0] IvWords [8] = '{
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
  };

  typedef struct packed {
    logic [WordW-1:0] data;
    logic [NbW-1:0]   nbytes;
    logic             last;
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMP,
    ST_PAD,
    ST_EMIT
  } core_state_e;

  function automatic logic [WordW-1:0] rotl32(input logic [WordW-1:0] x,
                                              input logic [4:0] n);
    logic [2*WordW-1:0] dbl;
    dbl = {x, x} << n;
    return dbl[2*WordW-1:WordW];
  endfunction

  function automatic logic [WordW-1:0] perm0(input logic [WordW-1:0] x);
    return x ^ {x[22:0], x[31:23]} ^ {x[14:0], x[31:15]};
  endfunction

  function automatic logic [WordW-1:0] perm1(input logic [WordW-1:0] x);
    return x ^ {x[16:0], x[31:17]} ^ {x[8:0], x[31:9]};
  endfunction

endpackage

[hdl/sm3_in_if.sv]
// ----------------------------------------------------------------------------
// SM3 input channel
// Valid/ready channel that carries one message word item.
// ----------------------------------------------------------------------------
interface sm3_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  valid_bytes;
  logic        last_word;

  modport source (output valid, data_word, valid_bytes, last_word, input ready);
  modport sink (input valid, data_word, valid_bytes, last_word, output ready);
endinterface

[hdl/sm3_out_if.sv]
// ----------------------------------------------------------------------------
// SM3 output channel
// Valid/ready channel that carries one digest word item.
// ----------------------------------------------------------------------------
interface sm3_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        digest_last;

  modport source (output valid, digest_word, word_index, digest_last, input ready);
  modport sink (input valid, digest_word, word_index, digest_last, output ready);
endinterface

[hdl/sm3_front.sv]
// ----------------------------------------------------------------------------
// SM3 front end
// Accepts input items, clamps the byte count and queues them in two entries.
// ----------------------------------------------------------------------------
module sm3_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  sm3_in_if.sink         in_i,
  output sm3_pkg::item_t item_o,
  output logic           item_valid_o,
  input  logic           item_ready_i
);
  import sm3_pkg::*;

  item_t       mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  item_t       item_in;
  logic        push, pop;

  always_comb begin
    item_in.data = in_i.data_word;
    item_in.last = in_i.last_word;
    if (!in_i.last_word || in_i.valid_bytes > 3'd4) begin
      item_in.nbytes = 3'd4;
    end else begin
      item_in.nbytes = in_i.valid_bytes;
    end
  end

  assign in_i.ready   = (cnt_q != 2'd2);
  assign push         = in_i.valid && in_i.ready;
  assign item_valid_o = (cnt_q != 2'd0);
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

[hdl/sm3_core.sv]
// ----------------------------------------------------------------------------
// SM3 back end
// Fills the block, pads the message, runs the rounds and emits the digest.
// ----------------------------------------------------------------------------
module sm3_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sm3_pkg::item_t item_i,
  input  logic           item_valid_i,
  output logic           item_ready_o,
  sm3_out_if.source      out_o
);
  import sm3_pkg::*;

  core_state_e      state_q, state_d, ret_q, ret_d;
  logic [WordW-1:0] w_q [BlkWords];
  logic [WordW-1:0] w_d [BlkWords];
  logic [WordW-1:0] r_q [8];
  logic [WordW-1:0] r_d [8];
  logic [WordW-1:0] cv_q [8];
  logic [WordW-1:0] cv_d [8];
  logic [WordW-1:0] rn [8];
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [4:0]       wpos_q, wpos_d;
  logic [5:0]       rnd_q, rnd_d;
  logic             pad80_q, pad80_d;
  logic             lenhi_q, lenhi_d;
  logic [2:0]       idx_q, idx_d;
  logic             ov_q, ov_d;
  logic [WordW-1:0] od_q, od_d;
  logic [2:0]       oi_q, oi_d;
  logic             ol_q, ol_d;
  logic [WordW-1:0] lastw, wnew, t, a12, ss1, ss2, ff, gg, tt1, tt2;
  logic [CntW+2:0]  bits;

  always_comb begin
    case (item_i.nbytes)
      3'd0:    lastw = PadWord;
      3'd1:    lastw = {item_i.data[31:24], 24'h800000};
      3'd2:    lastw = {item_i.data[31:16], 16'h8000};
      3'd3:    lastw = {item_i.data[31:8], 8'h80};
      default: lastw = item_i.data;
    endcase
  end

  always_comb begin
    if (rnd_q < 6'd16) begin
      t  = rotl32(TConstLow, rnd_q[4:0]);
      ff = r_q[0] ^ r_q[1] ^ r_q[2];
      gg = r_q[4] ^ r_q[5] ^ r_q[6];
    end else begin
      t  = rotl32(TConstHigh, 5'(rnd_q - 6'd16));
      ff = (r_q[0] & r_q[1]) | (r_q[0] & r_q[2]) | (r_q[1] & r_q[2]);
      gg = (r_q[4] & r_q[5]) | (~r_q[4] & r_q[6]);
    end
    a12 = {r_q[0][19:0], r_q[0][31:20]};
    ss1 = rotl32(a12 + r_q[4] + t, 5'd7);
    ss2 = ss1 ^ a12;
    tt1 = ff + r_q[3] + ss2 + (w_q[0] ^ w_q[4]);
    tt2 = gg + r_q[7] + ss1 + w_q[0];
    rn[0] = tt1;
    rn[1] = r_q[0];
    rn[2] = {r_q[1][22:0], r_q[1][31:23]};
    rn[3] = r_q[2];
    rn[4] = perm0(tt2);
    rn[5] = r_q[4];
    rn[6] = {r_q[5][12:0], r_q[5][31:13]};
    rn[7] = r_q[6];
    wnew = perm1(w_q[0] ^ w_q[7] ^ {w_q[13][16:0], w_q[13][31:17]})
           ^ {w_q[3][24:0], w_q[3][31:25]} ^ w_q[10];
    bits = {cnt_q, 3'b000};
  end

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    w_d     = w_q;
    r_d     = r_q;
    cv_d    = cv_q;
    cnt_d   = cnt_q;
    wpos_d  = wpos_q;
    rnd_d   = rnd_q;
    pad80_d = pad80_q;
    lenhi_d = 1'b0;
    idx_d   = idx_q;
    ov_d    = ov_q && !out_o.ready;
    od_d    = od_q;
    oi_d    = oi_q;
    ol_d    = ol_q;
    item_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          wpos_d = wpos_q + 5'd1;
          cnt_d  = cnt_q + CntW'(item_i.nbytes);
          if (!item_i.last) begin
            w_d[wpos_q[3:0]] = item_i.data;
            ret_d = ST_IDLE;
          end else begin
            w_d[wpos_q[3:0]] = lastw;
            pad80_d = (item_i.nbytes == 3'd4);
            ret_d   = ST_PAD;
            state_d = ST_PAD;
          end
          if (wpos_q[3:0] == 4'd15) begin
            state_d = ST_COMP;
            r_d     = cv_q;
            rnd_d   = 6'd0;
          end
        end
      end
      ST_PAD: begin
        if (wpos_q[4]) begin
          state_d = ST_COMP;
          ret_d   = ST_PAD;
          r_d     = cv_q;
          rnd_d   = 6'd0;
        end else begin
          wpos_d = wpos_q + 5'd1;
          if (pad80_q) begin
            w_d[wpos_q[3:0]] = PadWord;
            pad80_d = 1'b0;
          end else if (wpos_q[3:0] == 4'd14) begin
            w_d[wpos_q[3:0]] = bits[63:32];
            lenhi_d = 1'b1;
          end else if (wpos_q[3:0] == 4'd15 && lenhi_q) begin
            w_d[wpos_q[3:0]] = bits[31:0];
            state_d = ST_COMP;
            ret_d   = ST_EMIT;
            r_d     = cv_q;
            rnd_d   = 6'd0;
            idx_d   = 3'd0;
          end else begin
            w_d[wpos_q[3:0]] = '0;
          end
        end
      end
      ST_COMP: begin
        r_d   = rn;
        rnd_d = rnd_q + 6'd1;
        for (int i = 0; i < BlkWords - 1; i++) begin
          w_d[i] = w_q[i+1];
        end
        w_d[BlkWords-1] = wnew;
        if (rnd_q == 6'(Rounds - 1)) begin
          for (int i = 0; i < 8; i++) begin
            cv_d[i] = cv_q[i] ^ rn[i];
          end
          wpos_d  = 5'd0;
          state_d = ret_q;
        end
      end
      ST_EMIT: begin
        if (!ov_q || out_o.ready) begin
          ov_d  = 1'b1;
          od_d  = cv_q[idx_q];
          oi_d  = idx_q;
          ol_d  = (idx_q == 3'd7);
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            cv_d    = IvWords;
            cnt_d   = '0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      cv_q    <= IvWords;
      r_q     <= '{default: '0};
      cnt_q   <= '0;
      wpos_q  <= '0;
      rnd_q   <= '0;
      pad80_q <= 1'b0;
      lenhi_q <= 1'b0;
      idx_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      cv_q    <= cv_d;
      r_q     <= r_d;
      cnt_q   <= cnt_d;
      wpos_q  <= wpos_d;
      rnd_q   <= rnd_d;
      pad80_q <= pad80_d;
      lenhi_q <= lenhi_d;
      idx_q   <= idx_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q  <= w_d;
    od_q <= od_d;
    oi_q <= oi_d;
    ol_q <= ol_d;
  end

  assign out_o.valid       = ov_q;
  assign out_o.digest_word = od_q;
  assign out_o.word_index  = oi_q;
  assign out_o.digest_last = ol_q;
endmodule

[hdl/sm3_hash_engine.sv]
// A message word is queued in the two-entry front end and then stored into the block;
// every sixteenth word starts a compression (one round per cycle in the shared round
// unit), and while it runs the back end takes no new words.
// The last word adds padding, one or two compressions and the eight digest words on
// the output. Reset restores the initial value and clears the byte count.
// ----------------------------------------------------------------------------
// SM3 hash engine
// Top level: input queue front end and compression back end.
// ----------------------------------------------------------------------------
module sm3_hash_engine (
  input  logic  clk_i,
  input  logic  rst_ni,
  sm3_in_if.sink    in_i,
  sm3_out_if.source out_o
);
  import sm3_pkg::*;

  item_t item;
  logic  item_valid, item_ready;

  sm3_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready)
  );

  sm3_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .out_o        (out_o)
  );
endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SM3 hash engine testbench
// Sends message words through the input channel and checks every digest
// word against a behavioral SM3 model, under several flow-control phases.
// ----------------------------------------------------------------------------
module testbench;
  import sm3_pkg::*;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  nb;
    logic        last;
    int          phase;
  } msg_item_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #1 clk_i = ~clk_i;

  sm3_in_if  in_ch ();
  sm3_out_if out_ch ();

  sm3_hash_engine u_dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch));

  msg_item_t    pending_q[$];
  digest_item_t digest_q[$];
  int           send_idle, recv_stall;
  int           errors, mismatches, digests_seen, msgs_sent;
  longint       cycles;
  logic         in_acc = 1'b0;

  logic [31:0] hv[8];
  logic [31:0] blk[16];
  logic [60:0] byte_cnt;

  function automatic logic [31:0] rl(input logic [31:0] x, input int n);
    int k;
    k = n % 32;
    if (k == 0) return x;
    return (x << k) | (x >> (32 - k));
  endfunction

  task automatic sm3_compress();
    logic [31:0] w[68];
    logic [31:0] r[8];
    logic [31:0] t, a12, ss1, ss2, ff, gg, tt1, tt2;
    for (int j = 0; j < 16; j++) w[j] = blk[j];
    for (int j = 16; j < 68; j++) begin
      t = w[j-16] ^ w[j-9] ^ rl(w[j-3], 15);
      w[j] = (t ^ rl(t, 15) ^ rl(t, 23)) ^ rl(w[j-13], 7) ^ w[j-6];
    end
    for (int j = 0; j < 8; j++) r[j] = hv[j];
    for (int k = 0; k < 64; k++) begin
      t = (k < 16) ? rl(32'h79cc4519, k) : rl(32'h9d8a7a87, (k - 16) % 32);
      a12 = rl(r[0], 12);
      ss1 = rl(a12 + r[4] + t, 7);
      ss2 = ss1 ^ a12;
      if (k < 16) begin
        ff = r[0] ^ r[1] ^ r[2];
        gg = r[4] ^ r[5] ^ r[6];
      end else begin
        ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
        gg = (r[4] & r[5]) | (~r[4] & r[6]);
      end
      tt1 = ff + r[3] + ss2 + (w[k] ^ w[k+4]);
      tt2 = gg + r[7] + ss1 + w[k];
      r[3] = r[2];
      r[2] = rl(r[1], 9);
      r[1] = r[0];
      r[0] = tt1;
      r[7] = r[6];
      r[6] = rl(r[5], 19);
      r[5] = r[4];
      r[4] = tt2 ^ rl(tt2, 9) ^ rl(tt2, 17);
    end
    for (int j = 0; j < 8; j++) hv[j] ^= r[j];
  endtask

  task automatic put_byte(inout int pos, input logic [7:0] b);
    int sh;
    sh = 24 - 8 * (pos % 4);
    blk[pos / 4] = (blk[pos / 4] & ~(32'hff << sh)) | (32'(b) << sh);
    pos++;
    if (pos == 64) begin
      sm3_compress();
      pos = 0;
    end
  endtask

  task automatic hash_word(input msg_item_t it);
    int          pos, nv;
    logic [63:0] bits;
    digest_item_t d;
    pos = int'(byte_cnt[5:0]);
    if (!it.last) begin
      blk[pos / 4] = it.word;
      byte_cnt = byte_cnt + 61'd4;
      if (byte_cnt[5:0] == 6'd0) sm3_compress();
      return;
    end
    nv = (it.nb > 3'd4) ? 4 : int'(it.nb);
    for (int i = 0; i < nv; i++) put_byte(pos, it.word[31 - 8 * i -: 8]);
    byte_cnt = byte_cnt + 61'(nv);
    bits = {byte_cnt, 3'b000};
    put_byte(pos, 8'h80);
    while (pos != 56) put_byte(pos, 8'h00);
    for (int i = 0; i < 8; i++) put_byte(pos, bits[63 - 8 * i -: 8]);
    for (int i = 0; i < 8; i++) begin
      d.word = hv[i];
      d.idx = 3'(i);
      d.last = (i == 7);
      digest_q.push_back(d);
      hv[i] = IvWords[i];
    end
    byte_cnt = '0;
  endtask

  task automatic add_msg(input int nwords, input logic [2:0] nb, input int ph);
    msg_item_t it;
    for (int i = 0; i < nwords; i++) begin
      it.word = (nwords == 1 && $urandom_range(0, 3) == 0) ?
                ((i % 2) ? 32'hffffffff : 32'h0) : $urandom;
      it.last = (i == nwords - 1);
      it.nb = it.last ? nb : 3'($urandom_range(0, 7));
      it.phase = ph;
      pending_q.push_back(it);
      msgs_sent++;
    end
  endtask

  // Input handshake as seen at the rising edge.
  always @(posedge clk_i) begin
    in_acc <= rst_ni && in_ch.valid && in_ch.ready;
  end

  // Driver: applies the queue at the falling edge, holding an item until taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_acc) begin
        hash_word(pending_q.pop_front());
      end
      if (pending_q.size() > 0 && ($urandom_range(0, 99) >= send_idle ||
          (in_ch.valid && !in_acc))) begin
        in_ch.valid <= 1'b1;
        in_ch.data_word <= pending_q[0].word;
        in_ch.valid_bytes <= pending_q[0].nb;
        in_ch.last_word <= pending_q[0].last;
      end else begin
        in_ch.valid <= 1'b0;
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  // Monitor: samples accepted digest words at the rising edge.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      digests_seen++;
      if (digest_q.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("Unexpected digest item %h", out_ch.digest_word);
      end else if (digest_q[0].word !== out_ch.digest_word ||
                   digest_q[0].idx !== out_ch.word_index ||
                   digest_q[0].last !== out_ch.digest_last) begin
        errors++;
        if (mismatches++ < 10)
          $display("Mismatch: expected %h/%0d/%b, actual %h/%0d/%b",
                   digest_q[0].word, digest_q[0].idx, digest_q[0].last,
                   out_ch.digest_word, out_ch.word_index, out_ch.digest_last);
        void'(digest_q.pop_front());
      end else begin
        void'(digest_q.pop_front());
      end
    end
    if (cycles > 2000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int n;
    in_ch.valid = 1'b0;
    in_ch.data_word = '0;
    in_ch.valid_bytes = '0;
    in_ch.last_word = 1'b0;
    out_ch.ready = 1'b0;
    send_idle = 0;
    recv_stall = 0;
    errors = 0;
    mismatches = 0;
    digests_seen = 0;
    msgs_sent = 0;
    cycles = 0;
    byte_cnt = '0;
    for (int i = 0; i < 8; i++) hv[i] = IvWords[i];
    for (int i = 0; i < 16; i++) blk[i] = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty message, each tail length, junk byte counts, block edges.
    add_msg(1, 3'd0, 0);
    for (int b = 1; b <= 7; b++) add_msg(1, 3'(b), 0);
    add_msg(14, 3'd4, 0);
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 64; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 64; end
        default: begin send_idle = 15; recv_stall = 15; end
      endcase
      n = 0;
      while (n < 72) begin
        int len;
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 34) : $urandom_range(1, 8);
        add_msg(len, 3'($urandom_range(0, 7)), p);
        n += len;
      end
      while (pending_q.size() > 0 || digest_q.size() > 0) @(posedge clk_i);
    end
    repeat (200) @(posedge clk_i);
    $display("Sent %0d words in four flow-control phases, checked %0d digest words.",
             msgs_sent, digests_seen);
    if (errors == 0 && digest_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

[sm3_hash_engine.f]
hdl/sm3_pkg.sv
hdl/sm3_in_if.sv
hdl/sm3_out_if.sv
hdl/sm3_front.sv
hdl/sm3_core.sv
hdl/sm3_hash_engine.sv
tb/testbench.sv
